// File: src/moving_average_latency_predictor_defines.svh
// Assertion macros shared by the moving-average latency predictor RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef MOVING_AVERAGE_LATENCY_PREDICTOR_DEFINES_SVH
`define MOVING_AVERAGE_LATENCY_PREDICTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MALP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MALP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/malp_pkg.sv
// Shared types and constants of the moving-average latency predictor.
// Depends on nothing; used by the channel interfaces and all RTL modules.
package malp_pkg;

    typedef enum logic [0:0] {
        OP_RECORD  = 1'b0,
        OP_PREDICT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_PREDICTED      = 2'd0,
        STATUS_WARMUP         = 2'd1,
        STATUS_OVER_THRESHOLD = 2'd2,
        STATUS_NONPOSITIVE    = 2'd3
    } status_t;

    localparam int THRESHOLD_BITS = 48;

endpackage

// File: src/malp_if.sv
// Valid/ready channel interfaces of the moving-average latency predictor.
// Depends on malp_pkg for the operation and status types.
interface malp_req_if
    import malp_pkg::*;
#(
    parameter int TIME_BITS = 48
)
();
    logic                 valid;
    logic                 ready;
    op_t                  operation;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] window_low;
    logic [TIME_BITS-1:0] window_high;

    modport source (output valid, operation, now, window_low, window_high, input ready);
    modport sink (input valid, operation, now, window_low, window_high, output ready);
endinterface

interface malp_rsp_if
    import malp_pkg::*;
#(
    parameter int TIME_BITS = 48
)
();
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] predicted_low;
    logic [TIME_BITS-1:0] predicted_high;
    status_t              status;

    modport source (output valid, predicted_low, predicted_high, status, input ready);
    modport sink (input valid, predicted_low, predicted_high, status, output ready);
endinterface

interface malp_cfg_if
    import malp_pkg::*;
();
    logic                              valid;
    logic                              ready;
    logic signed [THRESHOLD_BITS-1:0] error_threshold;

    modport source (output valid, error_threshold, input ready);
    modport sink (input valid, error_threshold, output ready);
endinterface

// File: src/malp_predict_pipe.sv
// Result stage: scales the running sum down to the window mean and forms the saturated window bounds
// (in_now for both if unpredicted) in one pass into the result reg. Depends on malp_pkg, malp_if, defines.
`include "moving_average_latency_predictor_defines.svh"

module malp_predict_pipe
    import malp_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16,
    parameter int TIME_BITS    = 48
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic [TIME_BITS-1:0]                             in_now,
    input  status_t                                          in_status,
    input  logic signed [TIME_BITS+1+$clog2(WINDOW_DEPTH):0] in_sum,
    malp_rsp_if.source                                       rsp
);

    localparam int SUM_W = TIME_BITS + 2 + $clog2(WINDOW_DEPTH);
    localparam int SHIFT = $clog2(4 * WINDOW_DEPTH);
    localparam int QW    = SUM_W - 1 - SHIFT;
    localparam int OFF_W = QW + 2;
    localparam int ADD_W = ((OFF_W > TIME_BITS) ? OFF_W : TIME_BITS) + 1;

    localparam logic [ADD_W-1:0] TIME_MAX = ADD_W'({TIME_BITS{1'b1}});

    logic                 out_valid_reg;
    status_t              status_reg;
    logic [TIME_BITS-1:0] plo_reg;
    logic [TIME_BITS-1:0] phi_reg;
    logic [TIME_BITS-1:0] plo_next;
    logic [TIME_BITS-1:0] phi_next;
    logic                 load;
    logic [QW-1:0]        quotient;
    logic [SHIFT-1:0]     remainder;
    logic [SHIFT+1:0]     remainder3;
    logic [OFF_W-1:0]     off_hi;
    logic [ADD_W-1:0]     lo_sum;
    logic [ADD_W-1:0]     hi_sum;

    assign in_ready = !out_valid_reg || rsp.ready;
    assign load     = in_valid && in_ready;

    // The divisor 4 * WINDOW_DEPTH is a power of two, so the mean is the sum shifted down, and the
    // upper bound gains the carry out of three times the bits that are shifted out.
    assign quotient   = in_sum[SUM_W-2:SHIFT];
    assign remainder  = in_sum[SHIFT-1:0];
    assign remainder3 = (SHIFT+2)'(remainder) + (SHIFT+2)'({remainder, 1'b0});
    assign off_hi     = OFF_W'(quotient) + OFF_W'({quotient, 1'b0})
                        + OFF_W'(remainder3[SHIFT+1:SHIFT]);
    assign lo_sum     = ADD_W'(in_now) + ADD_W'(quotient);
    assign hi_sum     = ADD_W'(in_now) + ADD_W'(off_hi);

    always_comb
    begin
        if (in_status == STATUS_PREDICTED)
        begin
            plo_next = (lo_sum > TIME_MAX) ? '1 : lo_sum[TIME_BITS-1:0];
            phi_next = (hi_sum > TIME_MAX) ? '1 : hi_sum[TIME_BITS-1:0];
        end
        else
        begin
            plo_next = in_now;
            phi_next = in_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= in_status;
            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.predicted_low  = plo_reg;
    assign rsp.predicted_high = phi_reg;
    assign rsp.status         = status_reg;

    `MALP_ASSERT_IMPLY(a_window_order,
        rsp.valid && rsp.status == STATUS_PREDICTED,
        rsp.predicted_low <= rsp.predicted_high,
        "Predicted window has its bounds reversed.")
    `MALP_ASSERT_IMPLY(a_flat_window,
        rsp.valid && rsp.status != STATUS_PREDICTED,
        rsp.predicted_low == rsp.predicted_high,
        "Unpredicted result is not a single point.")
    `MALP_ASSERT_IMPLY(a_positive_sum,
        in_valid && in_status == STATUS_PREDICTED,
        !in_sum[SUM_W-1] && (in_sum != '0),
        "Prediction requested with a nonpositive running sum.")
    `MALP_ASSERT_NEXT(a_hold_result,
        rsp.valid && !rsp.ready,
        rsp.valid && $stable(rsp.predicted_low) && $stable(rsp.predicted_high)
            && $stable(rsp.status),
        "Waiting result transaction changed before it was taken.")

endmodule

// File: src/moving_average_latency_predictor.sv
// Moving-average latency predictor, top level; depends on malp_pkg, malp_if and malp_predict_pipe.
// Throughput is one transaction per cycle on the request channel, records and predictions alike,
// unless a stall holds it. A prediction result passes the input register, then the result register.
// A held result stalls requests once a prediction waits behind it.
// WINDOW_DEPTH must be a power of two, so that the window mean is a shift.
// Reset clears the fill count, write slot, running sum, threshold and valid flags, not the ring.
`include "moving_average_latency_predictor_defines.svh"

module moving_average_latency_predictor
    import malp_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16,
    parameter int TIME_BITS    = 48
)
(
    input  logic      clk,
    input  logic      rst_n,
    malp_req_if.sink  request,
    malp_rsp_if.source response,
    malp_cfg_if.sink  cfg
);

    localparam int DELTA_W = TIME_BITS + 2;
    localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = DELTA_W + $clog2(WINDOW_DEPTH);
    localparam int BOUND_W = THRESHOLD_BITS + $clog2(2 * WINDOW_DEPTH) + 1;
    localparam int CMP_W   = (SUM_W > BOUND_W) ? SUM_W : BOUND_W;

    localparam logic [SLOT_W-1:0]         LAST_SLOT   = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [FILL_W-1:0]         FULL_COUNT  = FILL_W'(WINDOW_DEPTH);
    localparam logic signed [BOUND_W-1:0] BOUND_SCALE = BOUND_W'(2 * WINDOW_DEPTH);

    logic                        s0_valid_reg;
    op_t                         s0_op_reg;
    logic [TIME_BITS-1:0]        s0_now_reg;
    logic signed [DELTA_W-1:0]   s0_delta_reg;
    logic signed [DELTA_W-1:0]   delta_next;

    logic                        s0_advance;
    logic                        record_fire;
    logic                        pipe_in_valid;
    logic                        pipe_in_ready;
    status_t                     pipe_status;

    logic signed [DELTA_W-1:0]   delta_ring_mem [WINDOW_DEPTH];
    logic signed [DELTA_W-1:0]   old_entry_reg;
    logic [SLOT_W-1:0]           write_slot_reg;
    logic [SLOT_W-1:0]           write_slot_next;
    logic [SLOT_W-1:0]           read_slot;
    logic [FILL_W-1:0]           fill_count_reg;
    logic [FILL_W-1:0]           fill_count_next;
    logic signed [SUM_W-1:0]     delta_sum_reg;
    logic signed [SUM_W-1:0]     delta_sum_next;
    logic signed [SUM_W-1:0]     evict;
    logic                        ring_full;

    logic signed [BOUND_W-1:0]   threshold_bound_reg;
    logic signed [BOUND_W-1:0]   bound_next;
    logic signed [BOUND_W-1:0]   threshold_ext;
    logic signed [CMP_W-1:0]     sum_cmp;
    logic signed [CMP_W-1:0]     bound_cmp;

    // Input register; the difference is kept in half ticks.
    assign delta_next = DELTA_W'({request.now, 1'b0}) - DELTA_W'(request.window_low)
                        - DELTA_W'(request.window_high);

    assign record_fire   = s0_valid_reg && (s0_op_reg == OP_RECORD);
    assign pipe_in_valid = s0_valid_reg && (s0_op_reg == OP_PREDICT);
    assign s0_advance    = record_fire || (pipe_in_valid && pipe_in_ready);
    assign request.ready = !s0_valid_reg || s0_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            s0_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            s0_op_reg    <= request.operation;
            s0_now_reg   <= request.now;
            s0_delta_reg <= delta_next;
        end
    end

    // Ring and running sum.
    assign ring_full       = (fill_count_reg == FULL_COUNT);
    assign evict           = ring_full ? SUM_W'(old_entry_reg) : '0;
    assign delta_sum_next  = delta_sum_reg + SUM_W'(s0_delta_reg) - evict;
    assign fill_count_next = ring_full ? fill_count_reg : fill_count_reg + 1'b1;
    assign write_slot_next = (write_slot_reg == LAST_SLOT) ? '0 : write_slot_reg + 1'b1;
    assign read_slot       = record_fire ? write_slot_next : write_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            fill_count_reg <= '0;
            delta_sum_reg  <= '0;
        end
        else if (record_fire)
        begin
            write_slot_reg <= write_slot_next;
            fill_count_reg <= fill_count_next;
            delta_sum_reg  <= delta_sum_next;
        end
    end

    // The read port keeps the entry under the write slot ready for eviction.
    always_ff @(posedge clk)
    begin
        if (record_fire)
        begin
            delta_ring_mem[write_slot_reg] <= s0_delta_reg;
        end
        old_entry_reg <= delta_ring_mem[read_slot];
    end

    // The threshold is stored already scaled to the sum: predict only if sum > -2 * depth * T.
    assign cfg.ready     = 1'b1;
    assign threshold_ext = BOUND_W'(cfg.error_threshold);
    assign bound_next    = -(threshold_ext * BOUND_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_bound_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            threshold_bound_reg <= bound_next;
        end
    end

    assign sum_cmp   = CMP_W'(delta_sum_reg);
    assign bound_cmp = CMP_W'(threshold_bound_reg);

    always_comb
    begin
        priority if (!ring_full)
        begin
            pipe_status = STATUS_WARMUP;
        end
        else if (!(sum_cmp > bound_cmp))
        begin
            pipe_status = STATUS_OVER_THRESHOLD;
        end
        else if (delta_sum_reg[SUM_W-1] || (delta_sum_reg == '0))
        begin
            pipe_status = STATUS_NONPOSITIVE;
        end
        else
        begin
            pipe_status = STATUS_PREDICTED;
        end
    end

    malp_predict_pipe #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TIME_BITS    (TIME_BITS)
    ) u_predict_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pipe_in_valid),
        .in_ready  (pipe_in_ready),
        .in_now    (s0_now_reg),
        .in_status (pipe_status),
        .in_sum    (delta_sum_reg),
        .rsp       (response)
    );

    `MALP_ASSERT_IMPLY(a_empty_sum,
        fill_count_reg == '0,
        delta_sum_reg == '0,
        "Running sum is nonzero while the ring is empty.")
    `MALP_ASSERT_NEXT(a_fill_step,
        record_fire && !ring_full,
        fill_count_reg == $past(fill_count_reg) + 1'b1,
        "Fill count did not advance on a record.")
    `MALP_ASSERT_IMPLY(a_slot_tracks_fill,
        !ring_full,
        write_slot_reg == SLOT_W'(fill_count_reg),
        "Write slot and fill count disagree during warm-up.")

endmodule
